[hw/rtl/annexb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_pkg
// Shared types and constants for the Annex B start code parser.
// ----------------------------------------------------------------------------
package annexb_pkg;

    // Fixed field widths of the descriptor.
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned IDX_W    = 32;
    localparam int unsigned OFS_W    = 32;
    localparam int unsigned PFX_W    = 3;
    localparam int unsigned PLEN_W   = 24;
    localparam int unsigned TYPE_W   = 5;
    localparam int unsigned IDC_W    = 2;

    // Reset value of the payload length limit.
    localparam logic [PLEN_W-1:0] MAX_LEN_RESET = 24'd100000;

    // Byte value that closes a start code.
    localparam logic [DATA_W-1:0] START_BYTE = 8'h01;

    // Header byte field masks.
    localparam logic [DATA_W-1:0] HDR_FORBIDDEN_MASK = 8'h80;
    localparam logic [DATA_W-1:0] HDR_REF_IDC_MASK   = 8'h60;
    localparam logic [DATA_W-1:0] HDR_TYPE_MASK      = 8'h1f;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_AWAIT = 2'd0,
        PH_HUNT  = 2'd1,
        PH_UNIT  = 2'd2
    } t_phase;

    // Descriptor status code.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_START  = 2'd1,
        ST_SATURATED = 2'd2
    } t_status;

    // One input item.
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              last_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [IDX_W-1:0]  nal_index;
        logic [OFS_W-1:0]  stream_offset;
        logic [PFX_W-1:0]  prefix_len;
        logic [PLEN_W-1:0] payload_len;
        logic              zero_bit;
        logic [IDC_W-1:0]  ref_idc;
        logic [TYPE_W-1:0] unit_type;
        t_status           status;
    } t_result;

endpackage

[hw/rtl/annexb_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_in_reg
// Input register: holds one accepted byte item until the parser takes it.
// ----------------------------------------------------------------------------
module annexb_in_reg
    import annexb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_ready,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    // The register can load whenever it is empty or drains this cycle.
    assign o_ready = !r_valid || i_take;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[hw/rtl/annexb_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_parser
// Start code detection, unit bookkeeping and descriptor formation, one byte
// per processing step.
// ----------------------------------------------------------------------------
module annexb_parser
    import annexb_pkg::*;
#(
    parameter int unsigned LEN_BITS = 24
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_in_item          i_item,
    input  logic              i_cfg_we,
    input  logic [PLEN_W-1:0] i_cfg_data,
    output logic              o_res_valid,
    output t_result           o_res
);

    // Comparison width covers both the counter and the limit register.
    localparam int unsigned CMP_W = (LEN_BITS > PLEN_W) ? LEN_BITS : PLEN_W;
    localparam logic [LEN_BITS-1:0] CAP     = '1;
    localparam logic [LEN_BITS-1:0] TRAIL_3 = LEN_BITS'(3);
    localparam logic [LEN_BITS-1:0] TRAIL_2 = LEN_BITS'(2);

    // State registers.
    logic [3*DATA_W-1:0] r_recent, n_recent;
    t_phase              r_phase, n_phase;
    logic [LEN_BITS-1:0] r_cnt, n_cnt;
    logic                r_four, n_four;
    logic [DATA_W-1:0]   r_hdr, n_hdr;
    logic [OFS_W-1:0]    r_off, n_off;
    logic [OFS_W-1:0]    r_pos, n_pos;
    logic [IDX_W-1:0]    r_counter, n_counter;
    logic [PLEN_W-1:0]   r_max_len;

    // Decode of the current byte.
    logic [DATA_W-1:0]   b;
    logic                last;
    logic                two_zero;
    logic                three_zero;
    logic                sc;
    logic [LEN_BITS-1:0] cnt_inc;
    logic [DATA_W-1:0]   hdr_new;
    logic                aw_found;
    logic                aw_fail;
    logic                aw_four;
    logic [OFS_W-1:0]    aw_off;
    logic [OFS_W-1:0]    hunt_off;

    // Descriptor source selection.
    logic                emit_unit;
    logic                emit_err;
    logic [LEN_BITS-1:0] e_cnt;
    logic [DATA_W-1:0]   e_hdr;
    logic [LEN_BITS-1:0] e_trail;
    logic [OFS_W-1:0]    e_off;
    logic                e_four;

    // Descriptor arithmetic.
    logic                sat;
    logic [LEN_BITS-1:0] len;
    logic [CMP_W-1:0]    len_ext;
    logic [DATA_W-1:0]   hdr_eff;
    logic                over;

    assign b          = i_item.data_byte;
    assign last       = i_item.last_byte;
    assign two_zero   = (r_recent[2*DATA_W-1:0] == '0);
    assign three_zero = (r_recent == '0);
    assign sc         = (b == START_BYTE) && two_zero;
    assign cnt_inc    = (r_cnt != CAP) ? (r_cnt + LEN_BITS'(1)) : r_cnt;
    assign hdr_new    = (r_cnt == '0) ? b : r_hdr;
    assign hunt_off   = r_pos - (three_zero ? OFS_W'(3) : OFS_W'(2));

    // Leading start code check: two zeros, then either 01 or a third zero
    // followed by 01.
    always_comb begin
        aw_found = 1'b0;
        aw_fail  = 1'b0;
        aw_four  = 1'b0;
        if (r_pos[OFS_W-1:1] == '0) begin
            aw_fail = (b != '0);
        end else if (r_pos == OFS_W'(2)) begin
            if (b == START_BYTE) begin
                aw_found = 1'b1;
            end else begin
                aw_fail = (b != '0);
            end
        end else begin
            if (b == START_BYTE) begin
                aw_found = 1'b1;
                aw_four  = 1'b1;
            end else begin
                aw_fail = 1'b1;
            end
        end
    end
    assign aw_off = r_pos - (aw_four ? OFS_W'(3) : OFS_W'(2));

    // Next state and descriptor selection.
    always_comb begin
        n_recent  = r_recent;
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_four    = r_four;
        n_hdr     = r_hdr;
        n_off     = r_off;
        n_pos     = r_pos;
        n_counter = r_counter;
        emit_unit = 1'b0;
        emit_err  = 1'b0;
        e_cnt     = r_cnt;
        e_hdr     = r_hdr;
        e_trail   = '0;
        e_off     = r_off;
        e_four    = r_four;

        case (r_phase)
            PH_AWAIT: begin
                if (aw_found) begin
                    n_four  = aw_four;
                    n_off   = aw_off;
                    n_cnt   = '0;
                    n_hdr   = '0;
                    n_phase = PH_UNIT;
                    if (last) begin
                        emit_unit = 1'b1;
                        e_cnt     = '0;
                        e_hdr     = '0;
                        e_off     = aw_off;
                        e_four    = aw_four;
                    end
                end else if (aw_fail || last) begin
                    emit_err = 1'b1;
                    n_phase  = PH_HUNT;
                end
            end
            PH_HUNT: begin
                if (sc && !last) begin
                    n_four  = three_zero;
                    n_off   = hunt_off;
                    n_cnt   = '0;
                    n_hdr   = '0;
                    n_phase = PH_UNIT;
                end
            end
            PH_UNIT: begin
                if (sc && !last) begin
                    // Close this unit; the zeros of the new prefix are trimmed.
                    emit_unit = 1'b1;
                    e_trail   = three_zero ? TRAIL_3 : TRAIL_2;
                    n_four    = three_zero;
                    n_off     = hunt_off;
                    n_cnt     = '0;
                    n_hdr     = '0;
                end else begin
                    n_hdr = hdr_new;
                    n_cnt = cnt_inc;
                    if (last) begin
                        emit_unit = 1'b1;
                        e_cnt     = cnt_inc;
                        e_hdr     = hdr_new;
                    end
                end
            end
            default: begin
                n_phase = PH_AWAIT;
            end
        endcase

        if (emit_unit) begin
            n_counter = r_counter + IDX_W'(1);
        end

        // The last byte returns the stream state to its reset values.
        if (last) begin
            n_recent  = '0;
            n_phase   = PH_AWAIT;
            n_cnt     = '0;
            n_four    = 1'b0;
            n_hdr     = '0;
            n_off     = '0;
            n_pos     = '0;
            n_counter = '0;
        end else begin
            n_recent = {r_recent[2*DATA_W-1:0], b};
            n_pos    = r_pos + OFS_W'(1);
        end
    end

    // Payload length, saturation and header fields.
    assign sat     = (e_cnt == CAP);
    assign len     = (e_cnt >= e_trail) ? (e_cnt - e_trail) : '0;
    assign len_ext = CMP_W'(len);
    assign hdr_eff = (len == '0) ? '0 : e_hdr;
    assign over    = sat || (len_ext > CMP_W'(r_max_len));

    // Descriptor assembly.
    always_comb begin
        o_res           = '0;
        o_res.nal_index = r_counter;
        if (emit_err) begin
            o_res.status = ST_NO_START;
        end else begin
            o_res.stream_offset = e_off;
            o_res.prefix_len    = e_four ? PFX_W'(4) : PFX_W'(3);
            o_res.payload_len   = over ? r_max_len : len_ext[PLEN_W-1:0];
            o_res.zero_bit      = |(hdr_eff & HDR_FORBIDDEN_MASK);
            o_res.ref_idc       = IDC_W'((hdr_eff & HDR_REF_IDC_MASK) >> 5);
            o_res.unit_type     = TYPE_W'(hdr_eff & HDR_TYPE_MASK);
            o_res.status        = over ? ST_SATURATED : ST_OK;
        end
    end

    // A byte yields a descriptor if it ends a unit or fails the start check.
    assign o_res_valid = emit_unit || emit_err;

    // State register update on each processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent  <= '0;
            r_phase   <= PH_AWAIT;
            r_cnt     <= '0;
            r_four    <= 1'b0;
            r_hdr     <= '0;
            r_off     <= '0;
            r_pos     <= '0;
            r_counter <= '0;
        end else if (i_fire) begin
            r_recent  <= n_recent;
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_four    <= n_four;
            r_hdr     <= n_hdr;
            r_off     <= n_off;
            r_pos     <= n_pos;
            r_counter <= n_counter;
        end
    end

    // Payload length limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

endmodule

[hw/rtl/annexb_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_out_reg
// Output register: holds one descriptor item until the consumer takes it.
// ----------------------------------------------------------------------------
module annexb_out_reg
    import annexb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // The slot is free when empty or when its item leaves this cycle.
    assign o_free = !r_valid || i_ready;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[hw/rtl/annexb_nalu_splitter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_nalu_splitter_core
// H.264 Annex B parser: one descriptor per NAL unit or per missing start code.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle and sustains that rate while the
// descriptor channel does not hold it back; the byte that closes a unit passes
// the input register, then one parser step into the output register, which
// presents its descriptor. The rate is set by the parser step, which updates
// the start code shift register, the unit byte counter and the offsets for
// each byte. A waiting descriptor does not block input until a second one
// is ready behind it. There is no clearing pass after reset. The payload
// length limit may be written only while no byte is in flight.
module annexb_nalu_splitter_core
    import annexb_pkg::*;
#(
    parameter int unsigned LEN_BITS = 24
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input byte channel.
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    // Configuration.
    input  logic              i_cfg_we,
    input  logic [23:0]       i_cfg_data,
    // Descriptor channel.
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_nal_index,
    output logic [31:0]       o_stream_offset,
    output logic [2:0]        o_prefix_len,
    output logic [23:0]       o_payload_len,
    output logic              o_zero_bit,
    output logic [1:0]        o_ref_idc,
    output logic [4:0]        o_unit_type,
    output logic [1:0]        o_status
);

    t_in_item in_item;
    t_in_item q_item;
    logic     q_valid;
    logic     out_free;
    logic     fire;
    logic     res_valid;
    logic     out_load;
    t_result  res;
    t_result  out_res;

    assign in_item.data_byte = i_data_byte;
    assign in_item.last_byte = i_last_byte;

    // A byte is processed when it is held and either produces no descriptor
    // or the output slot can take the one it produces.
    assign fire     = q_valid && (out_free || !res_valid);
    assign out_load = fire && res_valid;

    annexb_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_item),
        .o_ready (o_ready),
        .i_take  (fire),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    annexb_parser #(
        .LEN_BITS (LEN_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (q_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    annexb_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    // Descriptor fields to ports.
    assign o_nal_index     = out_res.nal_index;
    assign o_stream_offset = out_res.stream_offset;
    assign o_prefix_len    = out_res.prefix_len;
    assign o_payload_len   = out_res.payload_len;
    assign o_zero_bit      = out_res.zero_bit;
    assign o_ref_idc       = out_res.ref_idc;
    assign o_unit_type     = out_res.unit_type;
    assign o_status        = out_res.status;

endmodule
